// ===== src/ptc_pkg.sv =====
// Shared types and constants for the page translation block.
package ptc_pkg;

   localparam int VA_WIDTH  = 22;
   localparam int PA_WIDTH  = 18;
   localparam int PS_WIDTH  = 13;
   localparam int FC_WIDTH  = 7;
   localparam int CNT_WIDTH = 32;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 13;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAGE_SIZE     = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAMES_IN_USE = 1'b1;

   localparam logic [PS_WIDTH-1:0] PAGE_SIZE_RESET = 13'd4096;
   localparam logic [FC_WIDTH-1:0] FRAMES_RESET    = 7'd64;

   localparam int DIV_STEPS = VA_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);

   localparam logic [CNT_WIDTH-1:0] CNT_MAX = '1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_write;
      logic accept;
      logic div_step;
      logic pt_rd_vpn;
      logic hit_update;
      logic fault_start;
      logic own_rd;
      logic pt_rd_owner;
      logic clear_ref;
      logic evict;
      logic take;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic div_done;
      logic out_of_range;
      logic pt_valid;
      logic occupied;
      logic second_chance;
      logic rsp_busy;
   } status_type;

endpackage

// ===== src/ptc_if.sv =====
// Channel interfaces for the request and response beats.
interface ptc_req_if;
   logic                         valid;
   logic                         ready;
   logic [ptc_pkg::VA_WIDTH-1:0] byte_address;
   logic                         write_access;

   modport source (output valid, byte_address, write_access, input ready);
   modport sink (input valid, byte_address, write_access, output ready);
endinterface

interface ptc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ptc_pkg::PA_WIDTH-1:0]  physical_address;
   logic                          page_fault;
   logic                          victim_written_back;
   logic                          address_out_of_range;
   logic [ptc_pkg::CNT_WIDTH-1:0] fault_total;
   logic [ptc_pkg::CNT_WIDTH-1:0] writeback_total;

   modport source (output valid, physical_address, page_fault, victim_written_back,
                   address_out_of_range, fault_total, writeback_total, input ready);
   modport sink (input valid, physical_address, page_fault, victim_written_back,
                 address_out_of_range, fault_total, writeback_total, output ready);
endinterface

// ===== src/ptc_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module ptc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;
endmodule

// ===== src/ptc_ctrl.sv =====
// Sequencing state machine for translation, sweep and result hand-off.
module ptc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ptc_pkg::status_type status,
   output ptc_pkg::cmd_type    cmd
);
   import ptc_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DIV, ST_RANGE, ST_PT_CHECK, ST_SWEEP,
      ST_OWN_CHECK, ST_VIC_CHECK, ST_TAKE, ST_RESULT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = ST_RANGE;
         end
         ST_RANGE: begin
            if (status.out_of_range) begin
               state_in = ST_RESULT;
            end else begin
               cmd.pt_rd_vpn = 1'b1;
               state_in      = ST_PT_CHECK;
            end
         end
         ST_PT_CHECK: begin
            if (status.pt_valid) begin
               cmd.hit_update = 1'b1;
               state_in       = ST_RESULT;
            end else begin
               cmd.fault_start = 1'b1;
               state_in        = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            cmd.own_rd = 1'b1;
            state_in   = ST_OWN_CHECK;
         end
         ST_OWN_CHECK: begin
            if (!status.occupied) begin
               cmd.take = 1'b1;
               state_in = ST_RESULT;
            end else begin
               cmd.pt_rd_owner = 1'b1;
               state_in        = ST_VIC_CHECK;
            end
         end
         ST_VIC_CHECK: begin
            if (status.second_chance) begin
               cmd.clear_ref = 1'b1;
               state_in      = ST_SWEEP;
            end else begin
               cmd.evict = 1'b1;
               state_in  = ST_TAKE;
            end
         end
         ST_TAKE: begin
            cmd.take = 1'b1;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!status.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== src/ptc_datapath.sv =====
// Datapath: divider, page table and frame owner stores, clock hand, counters, result register.
module ptc_datapath #(
   parameter int VIRTUAL_PAGES = 1024,
   parameter int MAX_FRAMES    = 64,
   parameter int MAX_PAGE_SIZE = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ptc_pkg::cmd_type                      cmd,
   output ptc_pkg::status_type                   status,
   input  logic                                  csr_write_enable,
   input  logic [ptc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [ptc_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   input  logic [ptc_pkg::VA_WIDTH-1:0]          req_byte_address,
   input  logic                                  req_write_access,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ptc_pkg::PA_WIDTH-1:0]          rsp_physical_address,
   output logic                                  rsp_page_fault,
   output logic                                  rsp_victim_written_back,
   output logic                                  rsp_address_out_of_range,
   output logic [ptc_pkg::CNT_WIDTH-1:0]         rsp_fault_total,
   output logic [ptc_pkg::CNT_WIDTH-1:0]         rsp_writeback_total
);
   import ptc_pkg::*;

   localparam int VPW  = $clog2(VIRTUAL_PAGES);
   localparam int FW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int FCW  = $clog2(MAX_FRAMES + 1);
   localparam int STW  = FCW + 1;
   localparam int PTW  = FW + 3;
   localparam int PRW  = FW + PS_WIDTH;
   localparam int POS_VALID = FW + 2;
   localparam int POS_REF   = FW + 1;
   localparam int POS_DIRTY = FW;

   // Configuration.
   logic [PS_WIDTH-1:0] page_size_ff;
   logic [FC_WIDTH-1:0] frames_ff;
   logic [PS_WIDTH-1:0] ps_eff;
   logic [FCW-1:0]      frames_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff <= PAGE_SIZE_RESET;
         frames_ff    <= FRAMES_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PAGE_SIZE:     page_size_ff <= csr_write_data;
            CSR_FRAMES_IN_USE: frames_ff    <= csr_write_data[FC_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (page_size_ff == '0) begin
         ps_eff = PS_WIDTH'(1);
      end else if (32'(page_size_ff) > 32'(MAX_PAGE_SIZE)) begin
         ps_eff = PS_WIDTH'(MAX_PAGE_SIZE);
      end else begin
         ps_eff = page_size_ff;
      end
      if (frames_ff == '0) begin
         frames_eff = FCW'(1);
      end else if (32'(frames_ff) > 32'(MAX_FRAMES)) begin
         frames_eff = FCW'(MAX_FRAMES);
      end else begin
         frames_eff = FCW'(frames_ff);
      end
   end

   // Request capture and restoring divider, one quotient bit a cycle.
   logic                     wr_ff;
   logic [VA_WIDTH-1:0]      quo_ff, quo_in;
   logic [PS_WIDTH-1:0]      rem_ff, rem_in;
   logic [DIV_CNT_WIDTH-1:0] div_cnt_ff;
   logic [PS_WIDTH:0]        trial;
   logic [VPW-1:0]           vpn;

   always_comb begin
      trial = {rem_ff, quo_ff[VA_WIDTH-1]};
      if (trial >= {1'b0, ps_eff}) begin
         rem_in = PS_WIDTH'(trial - {1'b0, ps_eff});
         quo_in = {quo_ff[VA_WIDTH-2:0], 1'b1};
      end else begin
         rem_in = trial[PS_WIDTH-1:0];
         quo_in = {quo_ff[VA_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         quo_ff     <= req_byte_address;
         rem_ff     <= '0;
         wr_ff      <= req_write_access;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff     <= quo_in;
         rem_ff     <= rem_in;
         div_cnt_ff <= div_cnt_ff + DIV_CNT_WIDTH'(1);
      end
   end

   assign vpn = quo_ff[VPW-1:0];

   // Page table store and frame owner store.
   logic [VPW-1:0] clr_cnt_ff;
   logic           pt_we;
   logic [VPW-1:0] pt_waddr, pt_raddr;
   logic [PTW-1:0] pt_wdata, pt_rdata;
   logic [VPW-1:0] owner_page;

   ptc_ram #(.WIDTH(PTW), .DEPTH(VIRTUAL_PAGES)) u_page_table (
      .clock         (clock),
      .write_enable  (pt_we),
      .write_address (pt_waddr),
      .write_data    (pt_wdata),
      .read_enable   (cmd.pt_rd_vpn | cmd.pt_rd_owner),
      .read_address  (pt_raddr),
      .read_data     (pt_rdata)
   );

   logic [FW-1:0]         hand_ff;
   logic [MAX_FRAMES-1:0] occ_ff;

   ptc_ram #(.WIDTH(VPW), .DEPTH(MAX_FRAMES)) u_frame_owner (
      .clock         (clock),
      .write_enable  (cmd.take),
      .write_address (hand_ff),
      .write_data    (vpn),
      .read_enable   (cmd.own_rd),
      .read_address  (hand_ff),
      .read_data     (owner_page)
   );

   assign pt_raddr = cmd.pt_rd_owner ? owner_page : vpn;

   always_comb begin
      pt_we    = cmd.clr_write | cmd.hit_update | cmd.clear_ref | cmd.evict | cmd.take;
      pt_waddr = vpn;
      pt_wdata = '0;
      if (cmd.clr_write) begin
         pt_waddr = clr_cnt_ff;
      end else if (cmd.hit_update) begin
         pt_wdata = {1'b1, 1'b1, pt_rdata[POS_DIRTY] | wr_ff, pt_rdata[FW-1:0]};
      end else if (cmd.clear_ref) begin
         pt_waddr          = owner_page;
         pt_wdata          = pt_rdata;
         pt_wdata[POS_REF] = 1'b0;
      end else if (cmd.evict) begin
         pt_waddr            = owner_page;
         pt_wdata            = pt_rdata;
         pt_wdata[POS_VALID] = 1'b0;
      end else if (cmd.take) begin
         pt_wdata = {1'b1, 1'b1, wr_ff, hand_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_write) begin
         clr_cnt_ff <= clr_cnt_ff + VPW'(1);
      end
   end

   // Clock hand, sweep step count, counters and per-item flags.
   logic [STW-1:0]       steps_ff;
   logic [FCW-1:0]       hand_next_wide;
   logic [FW-1:0]        hand_next;
   logic [CNT_WIDTH-1:0] fault_cnt_ff, wb_cnt_ff;
   logic                 fault_flag_ff, wb_flag_ff;
   logic [FW-1:0]        frame_ff;

   assign hand_next_wide = FCW'(hand_ff) + FCW'(1);
   assign hand_next = (hand_next_wide == frames_eff) ? '0 : hand_next_wide[FW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         hand_ff      <= '0;
         occ_ff       <= '0;
         fault_cnt_ff <= '0;
         wb_cnt_ff    <= '0;
      end else begin
         if (cmd.fault_start) begin
            if (FCW'(hand_ff) >= frames_eff) hand_ff <= '0;
            if (fault_cnt_ff != CNT_MAX) fault_cnt_ff <= fault_cnt_ff + CNT_WIDTH'(1);
         end
         if (cmd.clear_ref) begin
            hand_ff <= hand_next;
         end
         if (cmd.evict && pt_rdata[POS_DIRTY]) begin
            if (wb_cnt_ff != CNT_MAX) wb_cnt_ff <= wb_cnt_ff + CNT_WIDTH'(1);
         end
         if (cmd.take) begin
            hand_ff         <= hand_next;
            occ_ff[hand_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         fault_flag_ff <= 1'b0;
         wb_flag_ff    <= 1'b0;
      end
      if (cmd.fault_start) begin
         fault_flag_ff <= 1'b1;
         steps_ff      <= '0;
      end
      if (cmd.clear_ref) begin
         steps_ff <= steps_ff + STW'(1);
      end
      if (cmd.evict) begin
         wb_flag_ff <= pt_rdata[POS_DIRTY];
      end
      if (cmd.hit_update) begin
         frame_ff <= pt_rdata[FW-1:0];
      end
      if (cmd.take) begin
         frame_ff <= hand_ff;
      end
   end

   // Result register.
   logic                  out_of_range;
   logic [PRW-1:0]        product;
   logic [PRW:0]          phys_sum;
   logic                  rsp_valid_ff;
   logic [PA_WIDTH-1:0]   phys_ff;
   logic                  fault_out_ff, wb_out_ff, oor_out_ff;
   logic [CNT_WIDTH-1:0]  fault_tot_ff, wb_tot_ff;

   assign out_of_range = ({{(32 - VA_WIDTH){1'b0}}, quo_ff} >= 32'(VIRTUAL_PAGES));
   assign product  = PRW'(frame_ff) * PRW'(ps_eff);
   assign phys_sum = (PRW + 1)'(product) + (PRW + 1)'(rem_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         phys_ff      <= out_of_range ? '0 : PA_WIDTH'(phys_sum);
         fault_out_ff <= fault_flag_ff & ~out_of_range;
         wb_out_ff    <= wb_flag_ff & ~out_of_range;
         oor_out_ff   <= out_of_range;
         fault_tot_ff <= fault_cnt_ff;
         wb_tot_ff    <= wb_cnt_ff;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_physical_address     = phys_ff;
   assign rsp_page_fault           = fault_out_ff;
   assign rsp_victim_written_back  = wb_out_ff;
   assign rsp_address_out_of_range = oor_out_ff;
   assign rsp_fault_total          = fault_tot_ff;
   assign rsp_writeback_total      = wb_tot_ff;

   // Status.
   always_comb begin
      status               = '0;
      status.clear_done    = (32'(clr_cnt_ff) == 32'(VIRTUAL_PAGES - 1));
      status.div_done      = (div_cnt_ff == DIV_CNT_WIDTH'(DIV_STEPS - 1));
      status.out_of_range  = out_of_range;
      status.pt_valid      = pt_rdata[POS_VALID];
      status.occupied      = occ_ff[hand_ff];
      status.second_chance = pt_rdata[POS_REF] && (steps_ff < {frames_eff, 1'b0});
      status.rsp_busy      = rsp_valid_ff & ~rsp_ready;
   end
endmodule

// ===== src/page_translate_clock_replace.sv =====
// Top level of the page translation block with clock replacement.
//
// This block translates one virtual byte address per request beat into a physical
// address, using a page table of VIRTUAL_PAGES entries and MAX_FRAMES physical frames
// managed by a second-chance clock hand. After reset the page table is cleared by a
// pass over the VIRTUAL_PAGES entries, during which no request is taken; configuration
// writes are taken at any time. Each request then works one item at a time: the address
// is split into page number and offset by a restoring divider that produces one quotient
// bit per cycle, then the range is checked and the page table is read. A miss adds the
// clock sweep: each frame the hand visits is read from the frame owner store and, if
// occupied, its owner's entry is read through the page table's single read port; at
// most twice the frame count plus one frames are visited. A finished response is held
// in an output register, so the next request is accepted while it waits to be taken.
module page_translate_clock_replace #(
   parameter int VIRTUAL_PAGES = 1024,
   parameter int MAX_FRAMES    = 64,
   parameter int MAX_PAGE_SIZE = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   ptc_req_if.sink                             req_chan,
   ptc_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [ptc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ptc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import ptc_pkg::*;

   // The controller and datapath exchange only these two bundles.
   cmd_type    cmd;
   status_type status;

   ptc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ptc_datapath #(
      .VIRTUAL_PAGES (VIRTUAL_PAGES),
      .MAX_FRAMES    (MAX_FRAMES),
      .MAX_PAGE_SIZE (MAX_PAGE_SIZE)
   ) u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .status                   (status),
      .csr_write_enable         (csr_write_enable),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data),
      .req_byte_address         (req_chan.byte_address),
      .req_write_access         (req_chan.write_access),
      .rsp_valid                (rsp_chan.valid),
      .rsp_ready                (rsp_chan.ready),
      .rsp_physical_address     (rsp_chan.physical_address),
      .rsp_page_fault           (rsp_chan.page_fault),
      .rsp_victim_written_back  (rsp_chan.victim_written_back),
      .rsp_address_out_of_range (rsp_chan.address_out_of_range),
      .rsp_fault_total          (rsp_chan.fault_total),
      .rsp_writeback_total      (rsp_chan.writeback_total)
   );
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the page translation block with clock replacement.
`timescale 1ns / 100ps

module testbench;
   import ptc_pkg::*;

   localparam int PAGES      = 1024;
   localparam int FRAMES     = 64;
   localparam int PAGE_MAX   = 4096;
   localparam int LIMIT      = 1500000;
   localparam int SETTLE     = 600;
   localparam int HOLD_LEN   = 3000;

   // Idling modes of the two channel ends.
   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [VA_WIDTH-1:0] va;
      logic                wr;
   } access_type;

   typedef struct {
      logic [PA_WIDTH-1:0]  pa;
      logic                 fault;
      logic                 wb;
      logic                 oor;
      logic [CNT_WIDTH-1:0] faults;
      logic [CNT_WIDTH-1:0] wbs;
   } xlate_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_idx = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   ptc_req_if req_bus();
   ptc_rsp_if rsp_bus();

   page_translate_clock_replace DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_we),
      .csr_index        (csr_idx),
      .csr_write_data   (csr_data)
   );

   // Mirror of the block's state, kept in step with every accepted beat.
   logic                 pt_valid [PAGES];
   logic                 pt_ref   [PAGES];
   logic                 pt_dirty [PAGES];
   logic [5:0]           pt_frame [PAGES];
   logic                 own_used [FRAMES];
   logic [9:0]           own_page [FRAMES];
   int unsigned          hand;
   logic [CNT_WIDTH-1:0] fault_cnt;
   logic [CNT_WIDTH-1:0] wb_cnt;
   logic [PS_WIDTH-1:0]  page_size_reg;
   logic [FC_WIDTH-1:0]  frames_reg;

   access_type    pending_q[$];
   xlate_type     awaited_q[$];
   idle_mode_type idle_mode = IDLE_NONE;
   logic       hold_go = 1'b0;
   logic       hold_on = 1'b0;
   int         errors = 0;
   int         items_pushed = 0;
   int         beats_in = 0;
   int         beats_out = 0;
   int         faults_seen = 0;
   int         wbs_seen = 0;
   int         oor_seen = 0;
   int         settings = 1;
   int unsigned cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned eff_page_size();
      if (page_size_reg == 0) return 1;
      if (page_size_reg > PAGE_MAX) return PAGE_MAX;
      return page_size_reg;
   endfunction

   function automatic int unsigned eff_frames();
      if (frames_reg == 0) return 1;
      if (frames_reg > FRAMES) return FRAMES;
      return frames_reg;
   endfunction

   function automatic logic [CNT_WIDTH-1:0] bump(logic [CNT_WIDTH-1:0] v);
      return (v == CNT_MAX) ? v : v + 1;
   endfunction

   // Translates one access and updates the mirrored table, owners and hand.
   function automatic xlate_type translate(access_type a);
      xlate_type r;
      int unsigned ps, fr, vpn, off, f, p, steps;
      longint unsigned phys;
      ps = eff_page_size();
      fr = eff_frames();
      vpn = a.va / ps;
      off = a.va % ps;
      r.fault = 1'b0;
      r.wb = 1'b0;
      r.oor = 1'b0;
      r.pa = '0;
      if (vpn >= PAGES) begin
         r.oor = 1'b1;
         r.faults = fault_cnt;
         r.wbs = wb_cnt;
         return r;
      end
      if (!pt_valid[vpn]) begin
         r.fault = 1'b1;
         fault_cnt = bump(fault_cnt);
         // Clock sweep: a referenced owner gets a second chance until twice the frame
         // count have been given, and the first frame that is empty or gets none is taken.
         if (hand >= fr) hand = 0;
         steps = 0;
         while (1) begin
            f = hand;
            hand = (f + 1) % fr;
            if (!own_used[f]) break;
            p = own_page[f];
            if (pt_ref[p] && steps < 2 * fr) begin
               pt_ref[p] = 1'b0;
               steps++;
               continue;
            end
            if (pt_dirty[p]) begin
               wb_cnt = bump(wb_cnt);
               r.wb = 1'b1;
            end
            pt_valid[p] = 1'b0;
            break;
         end
         own_used[f] = 1'b1;
         own_page[f] = vpn[9:0];
         pt_frame[vpn] = f[5:0];
         pt_valid[vpn] = 1'b1;
         pt_dirty[vpn] = 1'b0;
      end
      pt_ref[vpn] = 1'b1;
      if (a.wr) pt_dirty[vpn] = 1'b1;
      phys = longint'(pt_frame[vpn]) * ps + off;
      r.pa = phys[PA_WIDTH-1:0];
      r.faults = fault_cnt;
      r.wbs = wb_cnt;
      return r;
   endfunction

   task automatic report(string field, longint unsigned got, longint unsigned want);
      $display("MISMATCH beat %0d %s: got %0h, expected %0h", beats_out, field, got, want);
      errors++;
   endtask

   // Request driver: offers pending accesses, idling at random in the sender modes.
   always @(posedge clock) begin
      access_type a;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.byte_address <= '0;
         req_bus.write_access <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            a.va = req_bus.byte_address;
            a.wr = req_bus.write_access;
            awaited_q.push_back(translate(a));
            beats_in++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_q.size() != 0 &&
                !((idle_mode == IDLE_SEND && $urandom_range(99) < 49) ||
                  (idle_mode == IDLE_BOTH && $urandom_range(99) < 8))) begin
               a = pending_q.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.byte_address <= a.va;
               req_bus.write_access <= a.wr;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each beat against the oldest expectation and
   // decides the ready for the next edge.
   always @(posedge clock) begin
      xlate_type w;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            beats_out++;
            if (awaited_q.size() == 0) begin
               $display("MISMATCH response beat %0d arrived with nothing awaited", beats_out);
               errors++;
            end else begin
               w = awaited_q.pop_front();
               if (rsp_bus.physical_address !== w.pa)
                  report("physical_address", rsp_bus.physical_address, w.pa);
               if (rsp_bus.page_fault !== w.fault)
                  report("page_fault", rsp_bus.page_fault, w.fault);
               if (rsp_bus.victim_written_back !== w.wb)
                  report("victim_written_back", rsp_bus.victim_written_back, w.wb);
               if (rsp_bus.address_out_of_range !== w.oor)
                  report("address_out_of_range", rsp_bus.address_out_of_range, w.oor);
               if (rsp_bus.fault_total !== w.faults)
                  report("fault_total", rsp_bus.fault_total, w.faults);
               if (rsp_bus.writeback_total !== w.wbs)
                  report("writeback_total", rsp_bus.writeback_total, w.wbs);
               faults_seen += w.fault;
               wbs_seen += w.wb;
               oor_seen += w.oor;
            end
         end
         rsp_bus.ready <= !(hold_on ||
                            (idle_mode == IDLE_RECV && $urandom_range(99) < 49) ||
                            (idle_mode == IDLE_BOTH && $urandom_range(99) < 8));
      end
   end

   // Long receiver hold-off, counted here so that the input side fills and stalls.
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (HOLD_LEN) @(posedge clock);
      hold_on <= 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("Run stopped by the watchdog after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_data <= data;
      if (idx == CSR_PAGE_SIZE) page_size_reg = data[PS_WIDTH-1:0];
      else frames_reg = data[FC_WIDTH-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Sets both registers; the upper bits of the frame write are random so that
   // every data bit is exercised.
   task automatic configure(int unsigned ps, int unsigned fr);
      logic [CSR_DATA_WIDTH-1:0] d;
      write_csr(CSR_PAGE_SIZE, ps[CSR_DATA_WIDTH-1:0]);
      d = CSR_DATA_WIDTH'($urandom);
      d[FC_WIDTH-1:0] = fr[FC_WIDTH-1:0];
      write_csr(CSR_FRAMES_IN_USE, d);
      settings++;
   endtask

   task automatic push(int unsigned va, bit wr);
      access_type a;
      a.va = va[VA_WIDTH-1:0];
      a.wr = wr;
      pending_q.push_back(a);
      items_pushed++;
   endtask

   // Waits until every access is sent and answered, then lets the block settle.
   task automatic drain();
      while (pending_q.size() != 0 || req_bus.valid || awaited_q.size() != 0 ||
             beats_out < items_pushed)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Mostly a small working set of pages around the frame count so that hits,
   // second chances and evictions all occur; the rest is any address at all.
   task automatic random_phase(int n);
      int unsigned ps, fr, pg, va;
      ps = eff_page_size();
      fr = eff_frames();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 75) begin
            pg = $urandom_range(2 * fr + 2);
            if (pg >= PAGES) pg = $urandom_range(PAGES - 1);
            va = pg * ps + $urandom_range(ps - 1);
         end else begin
            va = $urandom_range((1 << VA_WIDTH) - 1);
         end
         push(va, $urandom_range(1));
      end
   endtask

   initial begin
      int unsigned ps, fr;
      for (int i = 0; i < PAGES; i++) begin
         pt_valid[i] = 1'b0;
         pt_ref[i] = 1'b0;
         pt_dirty[i] = 1'b0;
         pt_frame[i] = '0;
      end
      for (int i = 0; i < FRAMES; i++) begin
         own_used[i] = 1'b0;
         own_page[i] = '0;
      end
      hand = 0;
      fault_cnt = '0;
      wb_cnt = '0;
      page_size_reg = PAGE_SIZE_RESET;
      frames_reg = FRAMES_RESET;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset settings: address extremes, reads and writes, a hit.
      push(0, 0);
      push((1 << VA_WIDTH) - 1, 1);
      push(0, 1);
      push(4095, 0);
      push(4096, 1);
      push((1 << VA_WIDTH) - 1, 0);
      drain();

      // Page size of zero acts as one byte, frame count of zero as one frame.
      // A dirty page is evicted, and page numbers past the table are refused.
      configure(0, 0);
      push(5, 1);
      push(6, 0);
      push(6, 1);
      push(5, 0);
      push(1024, 0);
      push((1 << VA_WIDTH) - 1, 1);
      push(1023, 0);
      drain();

      // Register values above the maximum are clipped.
      configure((1 << PS_WIDTH) - 1, (1 << FC_WIDTH) - 1);
      push(12345, 1);
      push((1 << VA_WIDTH) - 1, 0);
      push(0, 0);
      push(4096 * 70, 1);
      drain();

      // Random phases over several settings and idling patterns.
      configure(4096, 64);
      idle_mode = IDLE_NONE;
      random_phase(100);
      drain();

      // Shrinking the frame count: the hand wraps and the upper frames keep
      // their pages.
      configure(100, 3);
      idle_mode = IDLE_SEND;
      random_phase(80);
      drain();

      // The long receiver hold-off falls in this phase.
      configure(13, 5);
      idle_mode = IDLE_RECV;
      hold_go = 1'b1;
      random_phase(80);
      drain();

      configure(1, 2);
      idle_mode = IDLE_BOTH;
      random_phase(80);
      drain();

      for (int k = 0; k < 3; k++) begin
         ps = $urandom_range(1, 4096);
         fr = $urandom_range(1, 64);
         configure(ps, fr);
         idle_mode = idle_mode_type'(k + 1);
         random_phase(70);
         drain();
      end

      configure(2048, 1);
      idle_mode = IDLE_NONE;
      random_phase(50);
      drain();

      if (awaited_q.size() != 0) begin
         $display("MISMATCH %0d responses never arrived", awaited_q.size());
         errors++;
      end
      $display("Covered %0d accesses over %0d register settings, %0d faults, %0d write-backs,",
               beats_in, settings, faults_seen, wbs_seen);
      $display("%0d out-of-range pages, with %0d mismatches", oor_seen, errors);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/ptc_pkg.sv
src/ptc_if.sv
src/ptc_ram.sv
src/ptc_ctrl.sv
src/ptc_datapath.sv
src/page_translate_clock_replace.sv
tb/sv/testbench.sv
